/* hdl/assert_macros.svh */
// Assertion macros used by the RTL file max_sum_sliding_window.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define MSW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define MSW_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define MSW_ASSERT(lbl, clk, rst_n, prop)

`define MSW_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* hdl/msw_pkg.sv */
// Package: constants, types and helpers of the sliding-window maximum-sum block.
package msw_pkg;

    localparam int MAX_WINDOW  = 256;
    localparam int MAX_LEN     = 65536;
    localparam int SAMPLE_BITS = 16;

    localparam int CFG_W    = 9;
    localparam int START_W  = 16;
    localparam int SUM_W    = 24;
    localparam int STATUS_W = 2;

    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W  = $clog2(MAX_LEN + 2);
    localparam int ACC_W  = SAMPLE_BITS + LEN_W + 1;

    localparam int START_MAX = (1 << START_W) - 1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [ACC_W-1:0]       t_acc;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic [START_W-1:0]            t_start;
    typedef logic [STATUS_W-1:0]           t_status;
    typedef logic [CFG_W-1:0]              t_cfg;
    typedef logic [LEN_W-1:0]              t_len;
    typedef logic [CNT_W-1:0]              t_cnt;
    typedef logic [ADDR_W-1:0]             t_addr;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_SHORT = 2'd1;
    localparam t_status ST_LONG  = 2'd2;

    typedef struct packed {
        logic    en;
        t_addr   addr;
        t_sample data;
    } t_ring_wr;

    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_ring_rd;

    function automatic t_len eff_len(input t_cfg w);
        if (w == '0) begin
            return LEN_W'(1);
        end else if (int'(w) > MAX_WINDOW) begin
            return LEN_W'(MAX_WINDOW);
        end else begin
            return LEN_W'(w);
        end
    endfunction

    function automatic t_sum sat_sum(input t_acc v);
        localparam t_acc HI = ACC_W'((1 << (SUM_W - 1)) - 1);
        localparam t_acc LO = -ACC_W'(1 << (SUM_W - 1));
        if (v > HI) begin
            return t_sum'(HI);
        end else if (v < LO) begin
            return t_sum'(LO);
        end else begin
            return SUM_W'(v);
        end
    endfunction

endpackage

/* hdl/msw_in_if.sv */
// Sample channel: valid/ready handshake with sample and last flag.
interface msw_in_if;
    import msw_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

/* hdl/msw_out_if.sv */
// Result channel: valid/ready handshake with best start, best sum and status.
interface msw_out_if;
    import msw_pkg::*;

    logic    valid;
    logic    ready;
    t_start  best_start;
    t_sum    best_sum;
    t_status status;

    modport source (output valid, output best_start, output best_sum, output status,
                    input ready);
    modport sink   (input valid, input best_start, input best_sum, input status,
                    output ready);
endinterface

/* hdl/msw_ring.sv */
// Ring store of window samples: one write port, one registered read port with bypass.
module msw_ring (
    input  logic               i_clk,
    input  msw_pkg::t_ring_wr  i_wr,
    input  msw_pkg::t_ring_rd  i_rd,
    output msw_pkg::t_sample   o_rd_data
);
    import msw_pkg::*;

    t_sample mem [MAX_WINDOW];
    t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            if (i_wr.en && (i_wr.addr == i_rd.addr)) begin
                r_rd_data <= i_wr.data;
            end else begin
                r_rd_data <= mem[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/max_sum_sliding_window.sv */
// A result is valid once the last sample has passed stage 1 into the result register.
// Throughput: one sample per cycle; input stalls only while a last sample waits on an
// unread result. The leaving sample comes from a registered ring read at transfer.
// Reset (i_rst_n low, synchronous): sequence state, window length (back to 1) and
// both pipeline valids clear; the ring store keeps its contents.
`include "assert_macros.svh"

module max_sum_sliding_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  msw_pkg::t_cfg     i_cfg_data,
    msw_in_if.sink            i_in,
    msw_out_if.source         o_res
);
    import msw_pkg::*;

    t_cfg    r_cfg_len;
    t_len    r_active_len;
    t_cnt    r_count;
    t_addr   r_wp;

    logic    r_s1_valid;
    t_sample r_s1_sample;
    logic    r_s1_last;
    logic    r_s1_live;
    logic    r_s1_first;
    logic    r_s1_sub;
    logic    r_s1_set;
    logic    r_s1_cmp;
    t_start  r_s1_start;
    t_status r_s1_status;
    t_addr   r_s1_wp;

    t_acc    r_sum;
    t_acc    r_best;
    t_start  r_best_idx;

    logic    r_out_valid;
    t_start  r_out_start;
    t_sum    r_out_sum;
    t_status r_out_status;

    logic    in_accept;
    logic    s1_go;
    logic    s0_first;
    t_len    s0_len;
    logic    s0_live;
    logic    s0_sub;
    t_cnt    s0_cnt_nx;
    t_cnt    s0_diff;
    t_status s0_status;
    t_start  s0_start;
    t_addr   s0_rd_addr;
    t_addr   s0_wp_nx;
    logic    s0_set;
    logic    s0_cmp;

    t_sample  old_sample;
    t_acc     n_sum;
    t_acc     n_best;
    t_start   n_best_idx;
    t_acc     s1_base;
    t_acc     s1_old;
    t_ring_wr ring_wr;
    t_ring_rd ring_rd;

    // input side
    assign s1_go     = r_s1_valid && (!r_s1_last || !r_out_valid || o_res.ready);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_accept = i_in.valid && i_in.ready;

    always_comb begin
        s0_first  = (r_count == '0);
        s0_len    = s0_first ? eff_len(r_cfg_len) : r_active_len;
        s0_live   = (r_count < CNT_W'(MAX_LEN));
        s0_sub    = s0_live && (r_count >= CNT_W'(s0_len));
        s0_cnt_nx = s0_live ? (r_count + CNT_W'(1)) : CNT_W'(MAX_LEN + 1);
        s0_set    = s0_live && (s0_cnt_nx == CNT_W'(s0_len));
        s0_cmp    = s0_live && (s0_cnt_nx > CNT_W'(s0_len));
        s0_diff   = s0_cnt_nx - CNT_W'(s0_len);
        s0_start  = (s0_diff > CNT_W'(START_MAX)) ? START_W'(START_MAX) : START_W'(s0_diff);

        priority if (s0_cnt_nx > CNT_W'(MAX_LEN)) begin
            s0_status = ST_LONG;
        end else if (s0_cnt_nx < CNT_W'(s0_len)) begin
            s0_status = ST_SHORT;
        end else begin
            s0_status = ST_OK;
        end

        if (LEN_W'(r_wp) >= s0_len) begin
            s0_rd_addr = ADDR_W'(LEN_W'(r_wp) - s0_len);
        end else begin
            s0_rd_addr = ADDR_W'(LEN_W'(r_wp) + LEN_W'(MAX_WINDOW) - s0_len);
        end

        if (LEN_W'(r_wp) + LEN_W'(1) >= LEN_W'(MAX_WINDOW)) begin
            s0_wp_nx = '0;
        end else begin
            s0_wp_nx = r_wp + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_cfg_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_len <= LEN_W'(1);
            r_count      <= '0;
            r_wp         <= '0;
        end else if (in_accept) begin
            r_active_len <= s0_len;
            if (i_in.last) begin
                r_count <= '0;
                r_wp    <= '0;
            end else begin
                r_count <= s0_cnt_nx;
                if (s0_live) begin
                    r_wp <= s0_wp_nx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sample <= i_in.sample;
            r_s1_last   <= i_in.last;
            r_s1_live   <= s0_live;
            r_s1_first  <= s0_first;
            r_s1_sub    <= s0_sub;
            r_s1_set    <= s0_set;
            r_s1_cmp    <= s0_cmp;
            r_s1_start  <= s0_start;
            r_s1_status <= s0_status;
            r_s1_wp     <= r_wp;
        end
    end

    // ring store
    assign ring_wr.en   = s1_go && r_s1_live;
    assign ring_wr.addr = r_s1_wp;
    assign ring_wr.data = r_s1_sample;
    assign ring_rd.en   = in_accept;
    assign ring_rd.addr = s0_rd_addr;

    msw_ring u_ring (
        .i_clk     (i_clk),
        .i_wr      (ring_wr),
        .i_rd      (ring_rd),
        .o_rd_data (old_sample)
    );

    // window update
    always_comb begin
        s1_base = r_s1_first ? '0 : r_sum;
        s1_old  = r_s1_sub ? ACC_W'(old_sample) : '0;
        n_sum   = s1_base - s1_old + ACC_W'(r_s1_sample);

        priority if (r_s1_set) begin
            n_best     = n_sum;
            n_best_idx = '0;
        end else if (r_s1_cmp && (n_sum >= r_best)) begin
            n_best     = n_sum;
            n_best_idx = r_s1_start;
        end else begin
            n_best     = r_best;
            n_best_idx = r_best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_live) begin
            r_sum      <= n_sum;
            r_best     <= n_best;
            r_best_idx <= n_best_idx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out_status <= r_s1_status;
            if (r_s1_status == ST_OK) begin
                r_out_start <= n_best_idx;
                r_out_sum   <= sat_sum(n_best);
            end else begin
                r_out_start <= '0;
                r_out_sum   <= '0;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.best_start = r_out_start;
    assign o_res.best_sum   = r_out_sum;
    assign o_res.status     = r_out_status;

    `MSW_ASSERT(a_last_clears, i_clk, i_rst_n, in_accept && i_in.last |=> r_count == '0)
    `MSW_ASSERT(a_result_loaded, i_clk, i_rst_n, s1_go && r_s1_last |=> r_out_valid)
    `MSW_ASSERT(a_wp_hold, i_clk, i_rst_n, in_accept && !s0_live |=> r_wp == $past(r_wp))
    `MSW_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(MAX_LEN + 1))
    `MSW_ASSERT_NEVER(a_len_range, i_clk, i_rst_n, r_active_len == '0 || r_active_len > LEN_W'(MAX_WINDOW))

endmodule

/* dv/tb_max_sum_sliding_window.sv */
// Testbench for the maximum-sum sliding window: directed table, extreme runs and random sequences.
`timescale 1ns / 1ps

module tb_max_sum_sliding_window;
    import msw_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int DIRECTED_ROWS = 20;
    localparam t_sample S_MAX = 16'sh7FFF;
    localparam t_sample S_MIN = 16'sh8000;

    typedef struct packed {
        t_start  first_idx;
        t_sum    total;
        t_status status;
    } t_best_window;

    typedef struct {
        bit           we;
        t_cfg         cfg;
        t_sample      s;
        logic         last;
        bit           typed;
        t_best_window want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg i_cfg_data;

    msw_in_if  samples_if ();
    msw_out_if best_if ();

    max_sum_sliding_window i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (samples_if),
        .o_res      (best_if)
    );

    t_best_window pending_best[$];
    int unsigned  results_sent;
    int unsigned  bad_results;
    int unsigned  quiet_cycles;
    bit           idle_on;

    t_sample      ring [MAX_WINDOW];
    longint       window_total;
    longint       best_total;
    int unsigned  best_at;
    int unsigned  seen;
    int unsigned  head;
    t_cfg         window_reg;
    int unsigned  span;

    t_dir_row directed [DIRECTED_ROWS];

    function automatic int unsigned window_span(input t_cfg w);
        if (w == '0) begin
            return 1;
        end else if (int'(w) > MAX_WINDOW) begin
            return MAX_WINDOW;
        end
        return int'(w);
    endfunction

    function automatic void restart_sequence();
        window_total = 0;
        best_total = 0;
        best_at = 0;
        seen = 0;
        head = 0;
    endfunction

    function automatic bit track_best_window(input t_sample s, input logic l,
                                             output t_best_window r);
        int unsigned n;
        int unsigned tail;
        longint      clipped;
        r = '0;
        r.status = ST_OK;
        if (seen == 0) begin
            span = window_span(window_reg);
        end
        if (seen < MAX_LEN) begin
            n = seen;
            if (n >= span) begin
                tail = (head + MAX_WINDOW - span) % MAX_WINDOW;
                window_total -= longint'(ring[tail]);
            end
            window_total += longint'(s);
            ring[head] = s;
            head = (head + 1) % MAX_WINDOW;
            if (n + 1 == span) begin
                best_total = window_total;
                best_at = 0;
            end else if (n + 1 > span && window_total >= best_total) begin
                best_total = window_total;
                best_at = n + 1 - span;
            end
            seen = n + 1;
        end else begin
            seen = MAX_LEN + 1;
        end
        if (!l) begin
            return 1'b0;
        end
        if (seen > MAX_LEN) begin
            r.status = ST_LONG;
        end else if (seen < span) begin
            r.status = ST_SHORT;
        end else begin
            r.first_idx = (best_at > START_MAX) ? t_start'(START_MAX) : t_start'(best_at);
            clipped = best_total;
            if (clipped > 64'sd8388607) begin
                clipped = 64'sd8388607;
            end
            if (clipped < -64'sd8388608) begin
                clipped = -64'sd8388608;
            end
            r.total = t_sum'(clipped);
        end
        restart_sequence();
        return 1'b1;
    endfunction

    function automatic t_sample draw_sample();
        case ($urandom_range(0, 7))
            0: return S_MAX;
            1: return S_MIN;
            2: return t_sample'(int'($urandom_range(0, 15)) - 8);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic push_sample(input t_sample s, input logic l, input bit typed,
                               input t_best_window given);
        t_best_window r;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            samples_if.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        samples_if.valid = 1'b1;
        samples_if.sample = s;
        samples_if.last = l;
        do @(posedge i_clk); while (samples_if.ready !== 1'b1);
        if (track_best_window(s, l, r)) begin
            pending_best.push_back(typed ? given : r);
            results_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic set_window(input t_cfg v);
        samples_if.valid = 1'b0;
        while (pending_best.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        window_reg = v;
    endtask

    // fill: 0 random, 1 all max, 2 all min, 3 random ending at max
    task automatic send_sequence(input int unsigned len, input int fill);
        t_sample s;
        for (int unsigned i = 0; i < len; i++) begin
            case (fill)
                1: s = S_MAX;
                2: s = S_MIN;
                default: s = draw_sample();
            endcase
            if (fill == 3 && i == len - 1) begin
                s = S_MAX;
            end
            push_sample(s, i == len - 1, 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        best_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                best_if.ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            best_if.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_best_window want;
        t_best_window got;
        if (best_if.valid === 1'b1 && best_if.ready === 1'b1) begin
            got.first_idx = best_if.best_start;
            got.total = best_if.best_sum;
            got.status = best_if.status;
            if (pending_best.size() == 0) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("unexpected result: start %0d sum %0d status %0d",
                             got.first_idx, got.total, got.status);
                end
            end else begin
                want = pending_best.pop_front();
                if (got.first_idx !== want.first_idx || got.total !== want.total
                        || got.status !== want.status) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("mismatch (start sum status): exp %0d %0d %0d, got %0d %0d %0d",
                                 want.first_idx, want.total, want.status,
                                 got.first_idx, got.total, got.status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((samples_if.valid === 1'b1 && samples_if.ready === 1'b1)
                || (best_if.valid === 1'b1 && best_if.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned done;
        int unsigned base_results;
        int unsigned eff;
        int unsigned len;
        int unsigned nseq;
        t_cfg        w;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        samples_if.valid = 1'b0;
        samples_if.sample = '0;
        samples_if.last = 1'b0;
        idle_on = 1'b1;
        results_sent = 0;
        bad_results = 0;
        quiet_cycles = 0;
        window_reg = 9'd1;
        span = 1;
        restart_sequence();

        directed = '{
            '{1'b0, 9'd0,   16'sd5,  1'b1, 1'b1, '{16'd0, 24'sd5, ST_OK}},
            '{1'b1, 9'd0,   S_MIN,   1'b1, 1'b1, '{16'd0, -24'sd32768, ST_OK}},
            '{1'b1, 9'd3,   S_MAX,   1'b0, 1'b0, '0},
            '{1'b0, 9'd0,   S_MAX,   1'b0, 1'b0, '0},
            '{1'b0, 9'd0,   S_MAX,   1'b1, 1'b1, '{16'd0, 24'sd98301, ST_OK}},
            '{1'b1, 9'd4,   16'sd1,  1'b0, 1'b0, '0},
            '{1'b0, 9'd0,   16'sd2,  1'b1, 1'b1, '{16'd0, 24'sd0, ST_SHORT}},
            '{1'b1, 9'd511, 16'sd7,  1'b1, 1'b1, '{16'd0, 24'sd0, ST_SHORT}},
            '{1'b1, 9'd2,   16'sd1,  1'b0, 1'b0, '0},
            '{1'b0, 9'd0,   -16'sd3, 1'b0, 1'b0, '0},
            '{1'b0, 9'd0,   16'sd5,  1'b0, 1'b0, '0},
            '{1'b0, 9'd0,   16'sd5,  1'b1, 1'b0, '0},
            '{1'b0, 9'd0,   16'sd3,  1'b0, 1'b0, '0},
            '{1'b0, 9'd0,   16'sd1,  1'b0, 1'b0, '0},
            '{1'b0, 9'd0,   16'sd2,  1'b0, 1'b0, '0},
            '{1'b0, 9'd0,   16'sd2,  1'b1, 1'b0, '0},
            '{1'b1, 9'd1,   -16'sd1, 1'b0, 1'b0, '0},
            '{1'b0, 9'd0,   S_MAX,   1'b0, 1'b0, '0},
            '{1'b0, 9'd0,   S_MIN,   1'b1, 1'b0, '0},
            '{1'b1, 9'd257, 16'sd0,  1'b1, 1'b1, '{16'd0, 24'sd0, ST_SHORT}}
        };

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].we) begin
                set_window(directed[i].cfg);
            end
            push_sample(directed[i].s, directed[i].last, directed[i].typed, directed[i].want);
        end

        set_window(9'd256);
        send_sequence(256, 2);
        set_window(9'd16);
        send_sequence(20, 1);
        send_sequence(20, 3);

        done = 0;
        base_results = results_sent;
        while (done < 200 || results_sent < base_results + 10) begin
            idle_on = (done < 150) && ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 9) == 0 && done < 60) begin
                case ($urandom_range(0, 4))
                    0: w = 9'd0;
                    1: w = 9'd256;
                    2: w = 9'd257;
                    3: w = 9'd511;
                    default: w = t_cfg'($urandom_range(17, 511));
                endcase
            end else begin
                w = t_cfg'($urandom_range(1, 16));
            end
            set_window(w);
            eff = window_span(w);
            nseq = (eff > 32) ? 1 : $urandom_range(1, 6);
            repeat (nseq) begin
                case ($urandom_range(0, 9))
                    0, 1: len = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
                    2: len = eff;
                    default: len = eff + $urandom_range(1, 16);
                endcase
                send_sequence(len, 0);
                done += len;
            end
        end

        idle_on = 1'b0;
        set_window(9'd4);
        repeat (4) send_sequence(12, 0);

        samples_if.valid = 1'b0;
        while (pending_best.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (bad_results == 0 && pending_best.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
